// ----- src/egr_pkg.sv -----
// Shared types, constants and the exp factor table for the elliptical Gaussian ring pixel block.
`timescale 1ns / 1ps
`default_nettype none

package egr_pkg;

    localparam int SQ_STEPS = 31;
    localparam int EXP_BITS = 21;

    localparam logic [2:0] REG_CENTRE_X    = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y    = 3'd1;
    localparam logic [2:0] REG_COS_ANGLE   = 3'd2;
    localparam logic [2:0] REG_SIN_ANGLE   = 3'd3;
    localparam logic [2:0] REG_INV_AXIS    = 3'd4;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd5;
    localparam logic [2:0] REG_RING_RADIUS = 3'd6;
    localparam logic [2:0] REG_INV_TWO_SIG = 3'd7;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // square-root cell word: remainder and partial root
    typedef struct packed {
        logic        vld;
        logic [61:0] v;
        logic [61:0] res;
    } t_sq;

    // exp cell word: exponent bits, underflow flag, running product
    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [20:0] e;
        logic [31:0] p;
    } t_ex;

    typedef logic [EXP_BITS-1:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = val;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // exp(-2^(k-16)) in Q.31
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab    t;
        logic [63:0] w;
        t = '0;
        t[16] = 32'd790015084;
        for (int k = 15; k >= 0; k--) begin
            w    = isqrt64({32'd0, t[k+1]} << 31);
            t[k] = w[31:0];
        end
        for (int k = 17; k < EXP_BITS; k++) begin
            w    = ({32'd0, t[k-1]} * {32'd0, t[k-1]} + (64'd1 << 30)) >> 31;
            t[k] = w[31:0];
        end
        return t;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- src/egr_sqrt_cell.sv -----
// One restoring square-root cell: resolves one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module egr_sqrt_cell import egr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [4:0] i_step,
    input  wire t_sq        i_d,
    output t_sq             o_q
);

    logic        r_vld;
    logic [61:0] r_v;
    logic [61:0] r_res;
    logic [5:0]  sh;
    logic [61:0] b;
    logic [61:0] trial;
    logic [61:0] n_v;
    logic [61:0] n_res;

    always_comb begin
        sh    = 6'd60 - {i_step, 1'b0};
        b     = 62'd1 << sh;
        trial = i_d.res + b;
        if (i_d.v >= trial) begin
            n_v   = i_d.v - trial;
            n_res = (i_d.res >> 1) + b;
        end else begin
            n_v   = i_d.v;
            n_res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_res <= n_res;
        end
    end

    assign o_q = '{vld: r_vld, v: r_v, res: r_res};

endmodule

`default_nettype wire

// ----- src/egr_exp_cell.sv -----
// One exp cell: multiplies in the table factor for one exponent bit.
`timescale 1ns / 1ps
`default_nettype none

module egr_exp_cell import egr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [4:0] i_k,
    input  wire t_ex        i_d,
    output t_ex             o_q
);

    logic        r_vld;
    logic        r_zero;
    logic [20:0] r_e;
    logic [31:0] r_p;
    logic [31:0] fac;
    logic [63:0] prod;
    logic [31:0] n_p;

    always_comb begin
        fac  = EXP_TAB[i_k];
        prod = 64'(i_d.p) * 64'(fac) + (64'd1 << 30);
        n_p  = i_d.e[i_k] ? prod[62:31] : i_d.p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_d.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= i_d.zero;
            r_e    <= i_d.e;
            r_p    <= n_p;
        end
    end

    assign o_q = '{vld: r_vld, zero: r_zero, e: r_e, p: r_p};

endmodule

`default_nettype wire

// ----- src/egr_front.sv -----
// Front end: centre offset, rotation, axis scaling, rounding and radius squared.
`timescale 1ns / 1ps
`default_nettype none

module egr_front import egr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [15:0] i_pixel_x,
    input  wire logic [15:0] i_pixel_y,
    input  wire logic [15:0] i_centre_x,
    input  wire logic [15:0] i_centre_y,
    input  wire logic [15:0] i_cos_angle,
    input  wire logic [15:0] i_sin_angle,
    input  wire logic [15:0] i_inv_axis_ratio,
    output t_sq              o_q
);

    logic [5:0]         r_vld;
    logic signed [32:0] r1_xc, r1_ys, r1_yc, r1_xs;
    logic signed [33:0] r2_xp, r2_yp;
    logic signed [49:0] r3_yq;
    logic [23:0]        r3_xa;
    logic [23:0]        r4_xa;
    logic [29:0]        r4_ya;
    logic [47:0]        r5_x2;
    logic [59:0]        r5_y2;
    logic [61:0]        r6_v;

    logic signed [16:0] dx, dy, iar;
    logic signed [15:0] c, s;
    logic [33:0]        xmag;
    logic [33:0]        xsum;
    logic [49:0]        ymag;
    logic [49:0]        ysum;

    always_comb begin
        dx   = $signed({1'b0, i_pixel_x}) - $signed({1'b0, i_centre_x});
        dy   = $signed({1'b0, i_pixel_y}) - $signed({1'b0, i_centre_y});
        c    = $signed(i_cos_angle);
        s    = $signed(i_sin_angle);
        iar  = $signed({1'b0, i_inv_axis_ratio});
        xmag = r2_xp[33] ? 34'(-r2_xp) : 34'(r2_xp);
        xsum = xmag + 34'd512;
        ymag = r3_yq[49] ? 50'(-r3_yq) : 50'(r3_yq);
        ysum = ymag + (50'd1 << 19);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_xc <= 33'(dx) * 33'(c);
            r1_ys <= 33'(dy) * 33'(s);
            r1_yc <= 33'(dy) * 33'(c);
            r1_xs <= 33'(dx) * 33'(s);
            r2_xp <= 34'(r1_xc) + 34'(r1_ys);
            r2_yp <= 34'(r1_yc) - 34'(r1_xs);
            r3_yq <= 50'(r2_yp) * 50'(iar);
            r3_xa <= xsum[33:10];
            r4_xa <= r3_xa;
            r4_ya <= ysum[49:20];
            r5_x2 <= 48'(r4_xa) * 48'(r4_xa);
            r5_y2 <= 60'(r4_ya) * 60'(r4_ya);
            r6_v  <= 62'(r5_x2) + 62'(r5_y2);
        end
    end

    assign o_q = '{vld: r_vld[5], v: r6_v, res: 62'd0};

endmodule

`default_nettype wire

// ----- src/elliptical_gaussian_ring_pixel_top.sv -----
// Top level of the elliptical Gaussian ring pixel evaluator.
// Takes one Q12.4 pixel coordinate per word and returns amplitude *
// exp(-(r - R)^2 / (2 sigma^2)) as saturated Q16.16. One word is accepted
// per clock when not stalled; the path runs through front-end stages, the 31-cell
// square-root chain, the 21-cell exp chain and multiply stages. The pipeline only
// stalls when its last stage holds a word and the output register is full
// and not taken. Configuration registers are written through a plain write
// port and must only change while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module elliptical_gaussian_ring_pixel_top import egr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_pixel_x,
    input  wire logic [15:0] i_pixel_y,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_intensity,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    logic [15:0] r_centre_x, r_centre_y, r_cos_angle, r_sin_angle;
    logic [15:0] r_inv_axis_ratio, r_ring_radius;
    logic [31:0] r_amplitude, r_inv_two_sigma_sq;

    logic        en;
    logic        r_out_valid;
    logic [31:0] r_intensity;

    t_sq sq_chain [SQ_STEPS+1];
    t_ex ex_chain [EXP_BITS+1];

    logic [2:0]  r_pv;
    logic [30:0] r_d;
    logic [61:0] r_d2;
    logic [61:0] r_hi;
    logic [63:0] r_lo;
    logic        r_ev;
    logic        r_ez;
    logic [20:0] r_e;

    logic        r_mv;
    logic        r_mz;
    logic [63:0] r_prod;

    logic [30:0] root;
    logic [19:0] rr;
    logic [40:0] e_full;
    logic        big;
    logic [64:0] rnd;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x         <= 16'd0;
            r_centre_y         <= 16'd0;
            r_cos_angle        <= 16'd16384;
            r_sin_angle        <= 16'd0;
            r_inv_axis_ratio   <= 16'd1024;
            r_amplitude        <= 32'd0;
            r_ring_radius      <= 16'd0;
            r_inv_two_sigma_sq <= 32'd16777216;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTRE_X:    r_centre_x         <= i_cfg_data[15:0];
                REG_CENTRE_Y:    r_centre_y         <= i_cfg_data[15:0];
                REG_COS_ANGLE:   r_cos_angle        <= i_cfg_data[15:0];
                REG_SIN_ANGLE:   r_sin_angle        <= i_cfg_data[15:0];
                REG_INV_AXIS:    r_inv_axis_ratio   <= i_cfg_data[15:0];
                REG_AMPLITUDE:   r_amplitude        <= i_cfg_data;
                REG_RING_RADIUS: r_ring_radius      <= i_cfg_data[15:0];
                REG_INV_TWO_SIG: r_inv_two_sigma_sq <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_mv || !r_out_valid || i_ready;
    assign o_ready = en;

    egr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_valid),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_centre_x       (r_centre_x),
        .i_centre_y       (r_centre_y),
        .i_cos_angle      (r_cos_angle),
        .i_sin_angle      (r_sin_angle),
        .i_inv_axis_ratio (r_inv_axis_ratio),
        .o_q              (sq_chain[0])
    );

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        egr_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(g)),
            .i_d     (sq_chain[g]),
            .o_q     (sq_chain[g+1])
        );
    end

    // distance to ring, squared, scaled to the exponent
    always_comb begin
        root   = sq_chain[SQ_STEPS].res[30:0];
        rr     = {r_ring_radius, 4'd0};
        big    = r_hi[61:13] != '0;
        e_full = (41'(r_hi[12:0]) << 8) + 41'(r_lo[63:24]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_ev <= 1'b0;
        end else if (en) begin
            r_pv <= {r_pv[1:0], sq_chain[SQ_STEPS].vld};
            r_ev <= r_pv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d  <= (root >= 31'(rr)) ? root - 31'(rr) : 31'(rr) - root;
            r_d2 <= 62'(r_d) * 62'(r_d);
            r_hi <= 62'(r_d2[61:32]) * 62'(r_inv_two_sigma_sq);
            r_lo <= 64'(r_d2[31:0]) * 64'(r_inv_two_sigma_sq);
            r_ez <= big || (e_full[40:21] != '0);
            r_e  <= e_full[20:0];
        end
    end

    assign ex_chain[0] = '{vld: r_ev, zero: r_ez, e: r_e, p: ONE_Q31};

    for (genvar g = 0; g < EXP_BITS; g++) begin : g_exp
        egr_exp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_k     (5'(g)),
            .i_d     (ex_chain[g]),
            .o_q     (ex_chain[g+1])
        );
    end

    // amplitude scaling and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= ex_chain[EXP_BITS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mz   <= ex_chain[EXP_BITS].zero;
            r_prod <= 64'(r_amplitude) * 64'(ex_chain[EXP_BITS].p);
        end
    end

    assign rnd = 65'(r_prod) + (65'd1 << 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && r_mv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_mv) begin
            if (r_mz) begin
                r_intensity <= 32'd0;
            end else if (rnd[64:63] != 2'd0) begin
                r_intensity <= 32'hFFFF_FFFF;
            end else begin
                r_intensity <= rnd[62:31];
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_intensity = r_intensity;

    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_mv) |=> o_valid)
        else $error("final stage word not loaded into output register");

    a_underflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_mv && r_mz) |=> (o_intensity == 32'd0))
        else $error("large exponent did not give zero intensity");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_mv && o_valid))
        else $error("pipeline stalled without a full output");

    a_amp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_mv && r_amplitude == 32'd0 && !i_cfg_we) |=> (o_intensity == 32'd0))
        else $error("zero amplitude gave nonzero intensity");

endmodule

`default_nettype wire

// ----- sim/egr_checker.sv -----
// Checker for the elliptical Gaussian ring pixel block: predicts each intensity and compares.
`timescale 1ns / 1ps
`default_nettype none

module egr_checker import egr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [15:0] i_pixel_x,
    input  wire logic [15:0] i_pixel_y,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [31:0] i_intensity,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending
);

    logic [15:0] ctr_x, ctr_y, cos_q, sin_q, inv_q, radius;
    logic [31:0] amp, inv_2s2;
    logic [31:0] decay_tab [EXP_BITS];
    logic [31:0] intensity_q [$];
    int          errors;

    assign o_errors  = errors;
    assign o_pending = intensity_q.size();

    function automatic longint unsigned floor_sqrt(input longint unsigned val);
        longint unsigned rem, root, bit_w;
        rem   = val;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem  = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned rnd_mag(input longint signed v, input int sh);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : longint'(v);
        return (m + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [31:0] predict_intensity(input logic [15:0] px,
                                                      input logic [15:0] py);
        longint signed   dx, dy, c, s, xp, yp, yq;
        longint unsigned xa, ya, r, rr, d, d2, hi, lo, e, p, res;
        dx = longint'(px) - longint'(ctr_x);
        dy = longint'(py) - longint'(ctr_y);
        c  = longint'($signed(cos_q));
        s  = longint'($signed(sin_q));
        xp = dx * c + dy * s;
        yp = dy * c - dx * s;
        yq = yp * longint'(inv_q);
        xa = rnd_mag(xp, 10);
        ya = rnd_mag(yq, 20);
        r  = floor_sqrt(xa * xa + ya * ya);
        rr = longint'(radius) << 4;
        d  = (r >= rr) ? r - rr : rr - r;
        d2 = d * d;
        hi = (d2 >> 32) * longint'(inv_2s2);
        lo = (d2 & 64'hFFFF_FFFF) * longint'(inv_2s2);
        if (hi >= (64'd1 << 13)) return 32'd0;
        e = (hi << 8) + (lo >> 24);
        if (e >= (64'd1 << EXP_BITS)) return 32'd0;
        p = 64'd1 << 31;
        for (int k = 0; k < EXP_BITS; k++) begin
            if (e[k]) p = (p * longint'(decay_tab[k]) + (64'd1 << 30)) >> 31;
        end
        res = (longint'(amp) * p + (64'd1 << 30)) >> 31;
        if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
        return res[31:0];
    endfunction

    initial begin
        longint unsigned w;
        decay_tab[16] = 32'd790015084;
        for (int k = 15; k >= 0; k--) begin
            w = floor_sqrt(longint'(decay_tab[k+1]) << 31);
            decay_tab[k] = w[31:0];
        end
        for (int k = 17; k < EXP_BITS; k++) begin
            w = (longint'(decay_tab[k-1]) * longint'(decay_tab[k-1]) + (64'd1 << 30)) >> 31;
            decay_tab[k] = w[31:0];
        end
        errors = 0;
    end

    // newest prediction at the front, oldest at the back
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            ctr_x   <= 16'd0;
            ctr_y   <= 16'd0;
            cos_q   <= 16'd16384;
            sin_q   <= 16'd0;
            inv_q   <= 16'd1024;
            amp     <= 32'd0;
            radius  <= 16'd0;
            inv_2s2 <= 32'd16777216;
            intensity_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CENTRE_X:    ctr_x   <= i_cfg_data[15:0];
                    REG_CENTRE_Y:    ctr_y   <= i_cfg_data[15:0];
                    REG_COS_ANGLE:   cos_q   <= i_cfg_data[15:0];
                    REG_SIN_ANGLE:   sin_q   <= i_cfg_data[15:0];
                    REG_INV_AXIS:    inv_q   <= i_cfg_data[15:0];
                    REG_AMPLITUDE:   amp     <= i_cfg_data;
                    REG_RING_RADIUS: radius  <= i_cfg_data[15:0];
                    REG_INV_TWO_SIG: inv_2s2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                intensity_q.push_front(predict_intensity(i_pixel_x, i_pixel_y));
            if (i_out_valid && i_out_ready) begin
                if (intensity_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, i_intensity);
                end else begin
                    want = intensity_q.pop_back();
                    if (want !== i_intensity) begin
                        errors++;
                        $display("%0t: intensity expected %h, actual %h",
                                 $time, want, i_intensity);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench top for the elliptical Gaussian ring pixel block: stimulus, config phases, verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb import egr_pkg::*;;

    localparam int PHASES    = 12;
    localparam int PER_PHASE = 125;
    localparam int WD_LIMIT  = 5000;
    localparam int HOLD_LEN  = 300;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready, o_valid, i_ready;
    logic [15:0] i_pixel_x, i_pixel_y;
    logic [31:0] o_intensity;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          errors, pending;
    int          tx_idle, rx_idle, words_sent, idle_cycles;
    logic        rx_hold;
    logic [15:0] cx, cy, rad;

    elliptical_gaussian_ring_pixel_top dut (.*);

    egr_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_pixel_x, .i_pixel_y,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_intensity(o_intensity),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // leaves the write enable high; the caller drops it after the last write
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [15:0] px, input logic [15:0] py);
        if ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
    endtask

    task automatic set_phase(input int ph);
        logic [15:0] c, s, iq;
        logic [31:0] a, sg;
        case (ph)
            1: begin
                cx = 16'hFFFF; cy = 16'hFFFF; c = 16'hC000; s = 16'h0000;
                iq = 16'hFFFF; a = 32'hFFFF_FFFF; rad = 16'hFFFF; sg = 32'h0;
            end
            2: begin
                cx = 16'h8000; cy = 16'h8000; c = 16'h0000; s = 16'h4000;
                iq = 16'd1024; a = 32'hFFFF_FFFF; rad = 16'd8; sg = 32'hFFFF_FFFF;
            end
            3: begin
                cx = 16'h0000; cy = 16'h0000; c = 16'h8000; s = 16'h7FFF;
                iq = 16'h0000; a = 32'h0001_0000; rad = 16'd0; sg = 32'd1;
            end
            default: begin
                cx = 16'($urandom); cy = 16'($urandom);
                rad = 16'($urandom_range(0, 64));
                c = 16'($urandom_range(0, 32768) - 16384);
                s = 16'($urandom_range(0, 32768) - 16384);
                if ($urandom_range(9) == 0) begin
                    c = 16'($urandom);
                    s = 16'($urandom);
                end
                iq = 16'($urandom_range(1024, 4096));
                if ($urandom_range(4) == 0) iq = 16'($urandom);
                a  = $urandom;
                sg = $urandom_range(1, 1 << 16) << $urandom_range(0, 12);
                if ($urandom_range(7) == 0) sg = $urandom;
            end
        endcase
        cfg_write(REG_CENTRE_X, {16'($urandom), cx});
        cfg_write(REG_CENTRE_Y, {16'($urandom), cy});
        cfg_write(REG_COS_ANGLE, {16'($urandom), c});
        cfg_write(REG_SIN_ANGLE, {16'($urandom), s});
        cfg_write(REG_INV_AXIS, {16'($urandom), iq});
        cfg_write(REG_AMPLITUDE, a);
        cfg_write(REG_RING_RADIUS, {16'($urandom), rad});
        cfg_write(REG_INV_TWO_SIG, sg);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] px, py;
        int          span;
        i_rst_n = 1'b0; i_valid = 1'b0; i_pixel_x = '0; i_pixel_y = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        tx_idle = 22; rx_idle = 69; rx_hold = 1'b0; words_sent = 0; idle_cycles = 0;
        cx = '0; cy = '0; rad = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: corners, centre, axis points
        send_word(16'h0000, 16'h0000);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'hFFFF, 16'h0000);
        send_word(16'h0000, 16'hFFFF);
        send_word(16'h0010, 16'h0000);
        send_word(16'h0000, 16'h0010);
        send_word(16'h5555, 16'hAAAA);
        send_word(16'hAAAA, 16'h5555);
        drain();

        for (int ph = 1; ph <= PHASES; ph++) begin
            if (ph == 5) begin tx_idle = 69; rx_idle = 22; end
            if (ph == 9) begin tx_idle = 0;  rx_idle = 0;  end
            set_phase(ph);
            if (ph == 2) rx_hold = 1'b1;
            send_word(cx, cy);
            send_word(cx + (rad << 4), cy);
            send_word(cx, cy + (rad << 4));
            send_word(~cx, ~cy);
            for (int n = 0; n < PER_PHASE; n++) begin
                if ($urandom_range(99) < 60) begin
                    span = (int'(rad) << 5) + 64;
                    px = 16'(cx + $urandom_range(0, 2 * span) - span);
                    py = 16'(cy + $urandom_range(0, 2 * span) - span);
                end else begin
                    px = 16'($urandom); py = 16'($urandom);
                end
                send_word(px, py);
            end
            drain();
        end

        $display("Sent %0d pixel words over %0d register settings, with stalls, a long",
                 words_sent, PHASES + 1);
        $display("output hold-off and extreme angle, axis ratio, amplitude and width values.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
